// ----- rtl/core/lctd_pkg.sv -----
// Package with the types and constants shared by the location table decoder.
package lctd_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_OFFSET = 1'd1;

	localparam logic [3:0] FORM_NONE = 4'd15;
	localparam logic [3:0] FORM_LONG = 4'd14;
	localparam logic [3:0] FORM_NO_COL = 4'd13;
	localparam logic [3:0] FORM_NEW_LINE = 4'd10;

	localparam logic [5:0] VARINT_STEP = 6'd6;
	localparam logic [5:0] VARINT_LIMIT = 6'd32;

	typedef enum logic [2:0] {
		PH_HDR = 3'd0,
		PH_VAR = 3'd1,
		PH_NL1 = 3'd2,
		PH_NL2 = 3'd3,
		PH_SHORT = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] table_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] line;
		logic [31:0] end_line;
		logic [31:0] column;
		logic [31:0] end_column;
		logic        error;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  entry_form;
		logic [31:0] running_line;
		logic [31:0] unit_count;
		logic [31:0] varint_acc;
		logic [5:0]  varint_shift;
		logic [1:0]  field_index;
		logic [31:0] loc_column;
		logic [31:0] loc_end_column;
		logic        finished;
		logic        in_table;
	} state_t;

endpackage

// ----- rtl/core/location_table_decoder.sv -----
// Top level of the location table decoder: registers, handshakes and configuration.
//
//   channel   direction   signals                          transaction
//   item      in          item_valid, item_ready, item     one table byte with its last flag
//   result    out         result_valid, result_ready, result  one decoded location
//   cfg       in          cfg_we, cfg_index, cfg_data      one register write
//
// One table byte is taken per cycle; a byte waits in the input register and its
// decode step runs from there straight into the result register, which takes the result
// when the step fires on the byte that completes it. A stalled result holds the
// step, and the input register then fills and drops item_ready. Reset clears all decode
// state and the valid flags of both registers; no clearing pass is needed.
module location_table_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  lctd_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output lctd_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [lctd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lctd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lctd_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	state_t      st_q;
	state_t      st_nxt;
	logic        step_emit;
	result_t     step_res;
	logic        fire;
	logic [31:0] first_line_q;
	logic [23:0] target_offset_q;

	assign fire = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || fire;

	lctd_step u_step (
		.cur           (st_q),
		.item          (item_s1),
		.first_line    (first_line_q),
		.target_offset (target_offset_q),
		.nxt           (st_nxt),
		.emit          (step_emit),
		.res           (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_line_q <= '0;
			target_offset_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_FIRST_LINE) begin
				first_line_q <= cfg_data;
			end else if (cfg_index == REG_TARGET_OFFSET) begin
				target_offset_q <= cfg_data[23:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (fire) begin
				st_q <= st_nxt;
			end
			if (fire && step_emit) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step_emit) begin
			result <= step_res;
		end
	end

	// A full input register is the only thing that holds off new bytes.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1)
		else $error("item_ready low with an empty input register");

	// Once a table has given its result, no further result comes before its last byte.
	a_no_emit_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		fire && st_q.finished |-> !step_emit)
		else $error("result emitted after the table was finished");

	// A cut-off entry reports an all-zero location.
	a_error_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error |-> result.line == 32'd0 && result.column == 32'd0
			&& result.end_column == 32'd0)
		else $error("error result carries a nonzero location");

	// Every emitted location has matching start and end lines.
	a_line_end_matches: assert property (@(posedge clk) disable iff (!arst_n)
		fire && step_emit |=> result_valid && result.end_line == result.line)
		else $error("result end_line differs from line");

endmodule

// ----- rtl/core/lctd_step.sv -----
// Next-state and result logic for one table byte.
module lctd_step (
	input  lctd_pkg::state_t  cur,
	input  lctd_pkg::item_t   item,
	input  logic [31:0]       first_line,
	input  logic [23:0]       target_offset,
	output lctd_pkg::state_t  nxt,
	output logic              emit,
	output lctd_pkg::result_t res
);
	import lctd_pkg::*;

	logic [7:0]  b;
	logic        last;
	logic [3:0]  add;
	logic [32:0] cnt_sum;
	logic [31:0] acc_new;
	logic [31:0] zz;
	logic        done;
	logic        err;
	logic        restart;

	always_comb begin
		b = item.table_byte;
		last = item.last_byte;
		nxt = cur;
		done = 1'b0;
		err = 1'b0;
		restart = 1'b0;
		add = {1'b0, b[2:0]} + 4'd1;
		cnt_sum = {1'b0, cur.unit_count} + {29'd0, add};
		acc_new = cur.varint_acc;
		if (cur.varint_shift < VARINT_LIMIT) begin
			acc_new = cur.varint_acc | ({26'd0, b[5:0]} << cur.varint_shift);
		end
		zz = acc_new[0] ? (32'd0 - {1'b0, acc_new[31:1]}) : {1'b0, acc_new[31:1]};

		if (cur.finished) begin
			restart = last;
		end else begin
			unique case (cur.phase)
				PH_HDR: begin
					if (!cur.in_table) begin
						nxt.running_line = first_line;
					end
					nxt.in_table = 1'b1;
					nxt.unit_count = cnt_sum[32] ? 32'hFFFF_FFFF : cnt_sum[31:0];
					nxt.entry_form = b[6:3];
					if (b[6:3] == FORM_NONE) begin
						done = 1'b1;
					end else if (b[6:3] == FORM_LONG || b[6:3] == FORM_NO_COL) begin
						if (last) begin
							nxt.loc_column = '0;
							nxt.loc_end_column = '0;
							done = 1'b1;
						end else begin
							nxt.phase = PH_VAR;
							nxt.field_index = '0;
							nxt.varint_acc = '0;
							nxt.varint_shift = '0;
						end
					end else if (last) begin
						err = 1'b1;
					end else if (b[6:3] >= FORM_NEW_LINE) begin
						nxt.running_line = nxt.running_line + {28'd0, b[6:3] - FORM_NEW_LINE};
						nxt.phase = PH_NL1;
					end else begin
						nxt.phase = PH_SHORT;
					end
				end
				PH_VAR: begin
					if (b[6] && !last) begin
						nxt.varint_acc = acc_new;
						if (cur.varint_shift < VARINT_LIMIT) begin
							nxt.varint_shift = cur.varint_shift + VARINT_STEP;
						end
					end else begin
						nxt.varint_acc = '0;
						nxt.varint_shift = '0;
						nxt.field_index = cur.field_index + 2'd1;
						unique case (cur.field_index)
							2'd0: begin
								nxt.running_line = cur.running_line + zz;
								if (cur.entry_form == FORM_NO_COL || last) begin
									nxt.loc_column = '0;
									nxt.loc_end_column = '0;
									done = 1'b1;
								end
							end
							2'd1: begin
								// The end-line delta is read and dropped.
								if (last) begin
									nxt.loc_column = '0;
									nxt.loc_end_column = '0;
									done = 1'b1;
								end
							end
							2'd2: begin
								nxt.loc_column = acc_new;
								if (last) begin
									nxt.loc_end_column = '0;
									done = 1'b1;
								end
							end
							default: begin
								nxt.loc_end_column = acc_new;
								done = 1'b1;
							end
						endcase
					end
				end
				PH_NL1: begin
					if (last) begin
						err = 1'b1;
					end else begin
						nxt.loc_column = 32'd1 + {24'd0, b};
						nxt.phase = PH_NL2;
					end
				end
				PH_NL2: begin
					nxt.loc_end_column = 32'd1 + {24'd0, b};
					done = 1'b1;
				end
				PH_SHORT: begin
					nxt.loc_column = 32'd1 + {25'd0, cur.entry_form, 3'd0} + {29'd0, b[6:4]};
					nxt.loc_end_column = nxt.loc_column + {28'd0, b[3:0]};
					done = 1'b1;
				end
				default: begin
					nxt.phase = PH_HDR;
					restart = last;
				end
			endcase
		end

		if (done) begin
			nxt.phase = PH_HDR;
		end
		emit = err || (done && (nxt.unit_count > {8'd0, target_offset} || last));

		res.error = err;
		res.line = err ? '0 : nxt.running_line;
		res.end_line = err ? '0 : nxt.running_line;
		res.column = err ? '0 : nxt.loc_column;
		res.end_column = err ? '0 : nxt.loc_end_column;

		if (emit) begin
			restart = last;
			nxt.finished = !last;
		end
		if (restart) begin
			nxt = '0;
			nxt.phase = PH_HDR;
			nxt.running_line = first_line;
		end
	end

endmodule
